FILE: rtl/kmd_pkg.sv
// Shared types and constants for the key matrix debounce and autorepeat block.
// Holds the scan and event word layouts and the configuration register map.
// No dependencies.
package kmd_pkg;

  localparam int RowW  = 3;
  localparam int ColW  = 8;
  localparam int TickW = 32;
  localparam int DelayW = 8;
  localparam int CfgIdxW = 1;
  localparam int CfgDataW = 8;

  localparam logic [CfgIdxW-1:0] RegStartDelay = 1'd0;
  localparam logic [CfgIdxW-1:0] RegNextDelay  = 1'd1;

  localparam logic [DelayW-1:0] StartDelayReset = 8'd31;
  localparam logic [DelayW-1:0] NextDelayReset  = 8'd15;

  typedef struct packed {
    logic [RowW-1:0]  row_index;
    logic [ColW-1:0]  column_raw;
    logic [TickW-1:0] now_ticks;
  } scan_t;

  typedef struct packed {
    logic [RowW-1:0] out_row;
    logic [ColW-1:0] pressed_bits;
    logic [ColW-1:0] repeat_bits;
    logic [ColW-1:0] released_bits;
  } key_event_t;

endpackage

FILE: rtl/kmd_if.sv
// Valid/ready channel interfaces for the key matrix block: row scans in, key events out.
// Depends on kmd_pkg for the word layouts.
interface kmd_scan_if;
  logic          valid;
  logic          ready;
  kmd_pkg::scan_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface kmd_event_if;
  logic               valid;
  logic               ready;
  kmd_pkg::key_event_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/key_matrix_debounce_repeat.sv
// Key matrix debounce with autorepeat: per-row vertical counter debounce and repeat timer.
// Depends on kmd_pkg and the channel interfaces in kmd_if.sv.
//
// Usage:
//   scan  (sink):   one word per sampled matrix row: row number, active-low column
//                   pins and the current tick count.
//   keys  (source): one word per scan that produced a press, release or repeat
//                   event for that row; scans with no event produce no word.
//   cfg_we/cfg_index/cfg_data: write the repeat start delay (index 0) and the
//                   repeat next delay (index 1); write only while the block is idle.
// Path: an accepted scan is held in the scan register s1, then its event word in out_word.
// Throughput: one scan per cycle while no event word waits on keys. The per-row state
//   is read and updated from the scan register in the same cycle, so consecutive scans
//   of the same row need no bubble.
// Reset: all keys released, vertical counters and repeat deadlines zero,
//   delays 31 and 15 ticks. The first scan is accepted the cycle after reset.
// Stall: while an event word waits on keys, one more scan is held in the
//   scan register and scan.ready drops until the event word is taken.
module key_matrix_debounce_repeat #(
  parameter int ROW_COUNT = 8,
  parameter int COL_COUNT = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  kmd_scan_if.sink                       scan,
  kmd_event_if.source                    keys,
  input  logic                           cfg_we,
  input  logic [kmd_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [kmd_pkg::CfgDataW-1:0]   cfg_data
);

  localparam int ColW   = kmd_pkg::ColW;
  localparam int TickW  = kmd_pkg::TickW;
  localparam int SelW   = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
  localparam logic [ColW-1:0] KeyMask =
    (COL_COUNT >= ColW) ? {ColW{1'b1}} : ColW'((64'd1 << COL_COUNT) - 64'd1);

  logic [kmd_pkg::DelayW-1:0] start_delay;
  logic [kmd_pkg::DelayW-1:0] next_delay;

  logic [ColW-1:0]  debounced [ROW_COUNT];
  logic [ColW-1:0]  vcount_low [ROW_COUNT];
  logic [ColW-1:0]  vcount_high [ROW_COUNT];
  logic [TickW-1:0] deadline [ROW_COUNT];

  logic             s1_valid;
  kmd_pkg::scan_t   s1;
  logic             s1_go;
  logic             out_valid;
  kmd_pkg::key_event_t out_word;

  logic [SelW-1:0]  sel;
  logic             row_ok;
  logic [ColW-1:0]  closed, st, diff, lo, hi, flip, st_next;
  logic [ColW-1:0]  press, release_bits, rep;
  logic [TickW-1:0] base, deadline_next, now_start, now_next;
  logic             fire, emit;

  assign s1_go      = s1_valid && (!out_valid || keys.ready);
  assign scan.ready = !s1_valid || s1_go;
  assign keys.valid = out_valid;
  assign keys.data  = out_word;

  always_comb begin
    sel    = SelW'({1'b0, s1.row_index});
    row_ok = ({29'd0, s1.row_index} < 32'(ROW_COUNT));
    closed = ~s1.column_raw & KeyMask;
    st     = debounced[sel];
    diff   = st ^ closed;
    lo     = ~(vcount_low[sel] & diff);
    hi     = lo ^ (vcount_high[sel] & diff);
    flip   = diff & lo & hi;
    st_next = st ^ flip;
    press        = st_next & flip & KeyMask;
    release_bits = ~st_next & flip & KeyMask;
    now_start = s1.now_ticks + TickW'(start_delay);
    now_next  = s1.now_ticks + TickW'(next_delay);
    base = ((st_next & KeyMask) == '0) ? now_start : deadline[sel];
    fire = (base <= s1.now_ticks);
    deadline_next = fire ? now_next : base;
    rep  = fire ? (st_next & KeyMask) : '0;
    emit = row_ok && ((press | rep | release_bits) != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_delay <= kmd_pkg::StartDelayReset;
      next_delay  <= kmd_pkg::NextDelayReset;
    end else if (cfg_we) begin
      case (cfg_index)
        kmd_pkg::RegStartDelay: start_delay <= cfg_data;
        kmd_pkg::RegNextDelay:  next_delay  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (scan.ready) begin
      s1_valid <= scan.valid;
    end
    if (scan.ready && scan.valid) begin
      s1 <= scan.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < ROW_COUNT; r++) begin
        debounced[r]   <= '0;
        vcount_low[r]  <= '0;
        vcount_high[r] <= '0;
        deadline[r]    <= '0;
      end
    end else if (s1_go && row_ok) begin
      debounced[sel]   <= st_next;
      vcount_low[sel]  <= lo;
      vcount_high[sel] <= hi;
      deadline[sel]    <= deadline_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go) begin
      out_valid <= emit;
    end else if (keys.ready) begin
      out_valid <= 1'b0;
    end
    if (s1_go && emit) begin
      out_word.out_row       <= s1.row_index;
      out_word.pressed_bits  <= press;
      out_word.repeat_bits   <= rep;
      out_word.released_bits <= release_bits;
    end
  end

endmodule

FILE: tb/key_matrix_debounce_repeat_tb.sv
// Testbench for key_matrix_debounce_repeat: directed and random row scans through
// several repeat delay settings, checked word by word against a built-in debounce predictor.
// Depends on kmd_pkg and the kmd_scan_if / kmd_event_if interfaces.
module key_matrix_debounce_repeat_tb;

  localparam int CycleLimit = 300000;
  localparam int QuietCycles = 6;
  localparam int RowW = kmd_pkg::RowW;
  localparam int ColW = kmd_pkg::ColW;
  localparam int TickW = kmd_pkg::TickW;
  localparam int DelayW = kmd_pkg::DelayW;

  typedef struct {
    kmd_pkg::scan_t word;
    bit    drain;
  } scan_job_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [kmd_pkg::CfgIdxW-1:0] cfg_index;
  logic [kmd_pkg::CfgDataW-1:0] cfg_data;

  kmd_scan_if  scan_if();
  kmd_event_if keys_if();

  key_matrix_debounce_repeat dut (
    .clk(clk),
    .rst(rst),
    .scan(scan_if),
    .keys(keys_if),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  logic [ColW-1:0]   key_state [8];
  logic [ColW-1:0]   vcnt_lo [8];
  logic [ColW-1:0]   vcnt_hi [8];
  logic [TickW-1:0]  repeat_due [8];
  logic [DelayW-1:0] start_delay;
  logic [DelayW-1:0] next_delay;

  scan_job_t  scan_backlog[$];
  kmd_pkg::key_event_t pending_events[$];
  int scans_queued;
  int scans_taken;
  int events_predicted;
  int events_checked;
  int errors;
  int cycles;
  bit steady;
  logic [TickW-1:0] tick_now;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic bit debounce_scan(input kmd_pkg::scan_t w,
                                       output kmd_pkg::key_event_t ev);
    logic [ColW-1:0] st, diff, lo, hi, rep;
    logic [RowW-1:0] r;
    r = w.row_index;
    st = key_state[r];
    diff = st ^ ~w.column_raw;
    lo = ~(vcnt_lo[r] & diff);
    hi = lo ^ (vcnt_hi[r] & diff);
    diff = diff & lo & hi;
    st = st ^ diff;
    vcnt_lo[r] = lo;
    vcnt_hi[r] = hi;
    key_state[r] = st;
    rep = '0;
    if (st == '0)
      repeat_due[r] = w.now_ticks + TickW'(start_delay);
    if (repeat_due[r] <= w.now_ticks) begin
      repeat_due[r] = w.now_ticks + TickW'(next_delay);
      rep = st;
    end
    ev.out_row = r;
    ev.pressed_bits = st & diff;
    ev.repeat_bits = rep;
    ev.released_bits = ~st & diff;
    return (ev.pressed_bits | ev.repeat_bits | ev.released_bits) != '0;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycles, msg);
    errors++;
  endtask

  task automatic queue_scan(input logic [RowW-1:0] row, input logic [ColW-1:0] raw,
                            input logic [TickW-1:0] ticks, input bit drain);
    scan_job_t job;
    job.word.row_index = row;
    job.word.column_raw = raw;
    job.word.now_ticks = ticks;
    job.drain = drain;
    scan_backlog.push_back(job);
    scans_queued++;
  endtask

  task automatic wait_quiet();
    while (scans_taken != scans_queued || events_predicted != events_checked)
      @(posedge clk);
    repeat (QuietCycles) @(posedge clk);
  endtask

  task automatic set_delays(input logic [DelayW-1:0] start_val,
                            input logic [DelayW-1:0] next_val);
    cfg_we <= 1'b1;
    cfg_index <= kmd_pkg::RegStartDelay;
    cfg_data <= start_val;
    @(posedge clk);
    cfg_index <= kmd_pkg::RegNextDelay;
    cfg_data <= next_val;
    @(posedge clk);
    cfg_we <= 1'b0;
    start_delay = start_val;
    next_delay = next_val;
  endtask

  task automatic fill_random_phase(input int count);
    logic [ColW-1:0] target [8];
    logic [ColW-1:0] raw;
    int r;
    int prev;
    int k;
    prev = 0;
    for (int i = 0; i < 8; i++)
      target[i] = '1;
    tick_now = $urandom;
    for (int i = 0; i < count; i++) begin
      r = ($urandom_range(99) < 30) ? prev : $urandom_range(7);
      prev = r;
      if ($urandom_range(99) < 6) begin
        case ($urandom_range(3))
          0: target[r] = '1;
          1: target[r] = ~(ColW'(1) << $urandom_range(ColW - 1));
          2: target[r] = ColW'($urandom);
          default: target[r] = ~((ColW'(1) << $urandom_range(ColW - 1)) |
                                 (ColW'(1) << $urandom_range(ColW - 1)));
        endcase
      end
      raw = target[r];
      k = $urandom_range(99);
      if (k < 8)
        raw = raw ^ (ColW'(1) << $urandom_range(ColW - 1));
      else if (k < 11)
        raw = ColW'($urandom);
      k = $urandom_range(99);
      if (k < 2)
        tick_now = $urandom;
      else if (k < 4)
        tick_now = 32'hFFFF_FF00 + $urandom_range(255);
      else
        tick_now = tick_now + $urandom_range(12);
      queue_scan(RowW'(r), raw, tick_now, i == count / 2);
    end
  endtask

  always @(posedge clk) begin
    bit take;
    bit hit;
    kmd_pkg::key_event_t ev;
    if (rst) begin
      scan_if.valid <= 1'b0;
    end else begin
      take = scan_if.valid && scan_if.ready;
      if (take) begin
        void'(scan_backlog.pop_front());
        scans_taken <= scans_taken + 1;
        hit = debounce_scan(scan_if.data, ev);
        if (hit) begin
          pending_events.push_back(ev);
          events_predicted <= events_predicted + 1;
        end
      end
      if (scan_if.valid && !take) begin
        scan_if.valid <= 1'b1;
      end else if (scan_backlog.size() != 0 && (steady || $urandom_range(99) >= 29) &&
                   (!scan_backlog[0].drain ||
                    (!scan_if.valid && events_predicted == events_checked))) begin
        scan_if.valid <= 1'b1;
        scan_if.data <= scan_backlog[0].word;
      end else begin
        scan_if.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    kmd_pkg::key_event_t want;
    kmd_pkg::key_event_t got;
    if (rst) begin
      keys_if.ready <= 1'b0;
    end else begin
      if (keys_if.valid && keys_if.ready) begin
        got = keys_if.data;
        if (pending_events.size() == 0) begin
          report_mismatch($sformatf("event word for row %0d with nothing expected",
                                    got.out_row));
        end else begin
          want = pending_events.pop_front();
          events_checked <= events_checked + 1;
          if (got.out_row !== want.out_row)
            report_mismatch($sformatf("out_row got %0h want %0h", got.out_row, want.out_row));
          if (got.pressed_bits !== want.pressed_bits)
            report_mismatch($sformatf("pressed_bits got %0h want %0h",
                                      got.pressed_bits, want.pressed_bits));
          if (got.repeat_bits !== want.repeat_bits)
            report_mismatch($sformatf("repeat_bits got %0h want %0h",
                                      got.repeat_bits, want.repeat_bits));
          if (got.released_bits !== want.released_bits)
            report_mismatch($sformatf("released_bits got %0h want %0h",
                                      got.released_bits, want.released_bits));
        end
      end
      keys_if.ready <= steady || ($urandom_range(99) >= 29);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAIL key_matrix_debounce_repeat");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    scan_if.valid = 1'b0;
    scan_if.data = '0;
    keys_if.ready = 1'b0;
    scans_queued = 0;
    scans_taken = 0;
    events_predicted = 0;
    events_checked = 0;
    errors = 0;
    cycles = 0;
    steady = 1'b0;
    start_delay = kmd_pkg::StartDelayReset;
    next_delay = kmd_pkg::NextDelayReset;
    for (int i = 0; i < 8; i++) begin
      key_state[i] = '0;
      vcnt_lo[i] = '0;
      vcnt_hi[i] = '0;
      repeat_due[i] = '0;
    end
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    @(negedge clk);
    queue_scan(3'd0, 8'hFF, 32'd0, 1'b0);
    queue_scan(3'd0, 8'h00, 32'd0, 1'b0);
    queue_scan(3'd7, 8'h00, 32'hFFFF_FFFF, 1'b0);
    queue_scan(3'd0, 8'h00, 32'd30, 1'b0);
    queue_scan(3'd0, 8'h00, 32'd31, 1'b0);
    queue_scan(3'd0, 8'hFE, 32'd40, 1'b0);
    for (int i = 0; i < 4; i++)
      queue_scan(3'd0, 8'hFF, 32'd50 + 32'(i * 10), 1'b0);
    queue_scan(3'd7, 8'h00, 32'd3, 1'b0);
    queue_scan(3'd7, 8'h00, 32'd14, 1'b0);
    queue_scan(3'd3, 8'hA5, 32'h8000_0000, 1'b0);
    queue_scan(3'd3, 8'h5A, 32'h8000_0001, 1'b0);
    queue_scan(3'd3, 8'hA5, 32'h8000_0002, 1'b0);
    queue_scan(3'd3, 8'h5A, 32'h8000_0003, 1'b0);
    for (int k = 0; k < ColW; k++)
      queue_scan(3'd5, ~(8'd1 << k), 32'h7FFF_FFF0 + 32'(k * 4), 1'b0);
    wait_quiet();

    set_delays(8'd0, 8'd0);
    @(negedge clk);
    fill_random_phase(190);
    wait_quiet();

    set_delays(8'd255, 8'd255);
    @(negedge clk);
    steady = 1'b1;
    fill_random_phase(190);
    wait_quiet();
    @(negedge clk);
    steady = 1'b0;

    set_delays(8'd1, 8'd0);
    @(negedge clk);
    fill_random_phase(190);
    wait_quiet();

    for (int p = 0; p < 2; p++) begin
      set_delays(DelayW'($urandom), DelayW'($urandom));
      @(negedge clk);
      fill_random_phase(190);
      wait_quiet();
    end

    if (pending_events.size() != 0)
      report_mismatch($sformatf("%0d event words never arrived", pending_events.size()));
    if (errors == 0) begin
      $display("PASS key_matrix_debounce_repeat");
    end else begin
      $display("FAIL key_matrix_debounce_repeat");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/kmd_pkg.sv
rtl/kmd_if.sv
rtl/key_matrix_debounce_repeat.sv
tb/key_matrix_debounce_repeat_tb.sv
